### rtl/grid_ray_wall_hit_macros.svh
// Assertion macros for the grid ray caster checker.
`ifndef GRID_RAY_WALL_HIT_MACROS_SVH
`define GRID_RAY_WALL_HIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define GRW_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grw: check failed");

// next-cycle implication, sampled on clk, off during rst
`define GRW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grw: check failed");

`endif

### rtl/grw_pkg.sv
// Constants, types and the tangent ROM of the grid ray caster.
package grw_pkg;

  localparam int MAP_SIDE    = 8;
  localparam int MAX_STEPS   = 8;
  localparam int ANGLE_W     = 10;
  localparam int ANGLE_STEPS = 1 << ANGLE_W;
  localparam int TILE_SHIFT  = 6;

  localparam int QTR        = ANGLE_STEPS / 4;
  localparam int HALF       = ANGLE_STEPS / 2;
  localparam int POS_SHIFT  = TILE_SHIFT + 8;   // tile size in Q8
  localparam int TILE_Q8    = 1 << POS_SHIFT;
  localparam int COORD_W    = 17;
  localparam int OUT_W      = 20;
  localparam int OUT_MAX    = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN    = -(1 << (OUT_W - 1));
  localparam int CELLS      = MAP_SIDE * MAP_SIDE;
  localparam int MAP_W      = 64;
  localparam int TAN_W      = 28;               // |tan| up to 2048.0 in Q16
  localparam int POS_W      = 34;               // internal signed Q8 positions
  localparam int DIST_W     = POS_SHIFT + 1;    // distance to first line, 1..TILE_Q8
  localparam int PROD_W     = DIST_W + TAN_W;
  localparam int IDX_W      = ANGLE_W - 2;
  localparam int ROM_DEPTH  = QTR;
  localparam int PIPE_DEPTH = 3 + MAX_STEPS + 1;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 64;
  localparam logic [CFG_AW-4:0] REG_WALL_MAP = '0;   // paddr[CFG_AW-1:3]

  localparam logic [TAN_W-1:0] TAN_SAT = TAN_W'(64'd2048 << 16);

  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint unsigned ONE_Q30    = 64'd1 << 30;

  typedef struct packed {
    logic signed [POS_W-1:0] rx;
    logic signed [POS_W-1:0] ry;
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic                    done;
    logic                    hit;
  } cast_t;

  typedef logic [TAN_W-1:0] tan_rom_t [ROM_DEPTH];

  // elaboration only: shift-subtract divide
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q30 sine or cosine by a truncating Taylor series, x^1..x^13
  function automatic longint unsigned sincos_q30(input longint unsigned t,
                                                 input logic want_cos);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned ts;
    longint unsigned tc;
    longint unsigned ss;
    longint unsigned cs;
    x  = (t * TWO_PI_Q30 + 64'(HALF)) / ANGLE_STEPS;
    x2 = (x * x) >> 30;
    ts = x;
    tc = ONE_Q30;
    ss = x;
    cs = ONE_Q30;
    ts = ((ts * x2) >> 30) / 6;   tc = ((tc * x2) >> 30) / 2;
    ss = ss - ts;                 cs = cs - tc;
    ts = ((ts * x2) >> 30) / 20;  tc = ((tc * x2) >> 30) / 12;
    ss = ss + ts;                 cs = cs + tc;
    ts = ((ts * x2) >> 30) / 42;  tc = ((tc * x2) >> 30) / 30;
    ss = ss - ts;                 cs = cs - tc;
    ts = ((ts * x2) >> 30) / 72;  tc = ((tc * x2) >> 30) / 56;
    ss = ss + ts;                 cs = cs + tc;
    ts = ((ts * x2) >> 30) / 110; tc = ((tc * x2) >> 30) / 90;
    ss = ss - ts;                 cs = cs - tc;
    ts = ((ts * x2) >> 30) / 156; tc = ((tc * x2) >> 30) / 132;
    ss = ss + ts;                 cs = cs + tc;
    return want_cos ? cs : ss;
  endfunction

  // |tan| of s steps, 1 <= s <= QTR, Q16 rounded, saturated
  function automatic logic [TAN_W-1:0] tan_entry(input int s);
    longint unsigned sn;
    longint unsigned cs;
    longint unsigned v;
    if (s >= QTR) begin
      v = 64'(TAN_SAT);
    end else if (2 * s <= QTR) begin
      sn = sincos_q30(64'(s), 1'b0);
      cs = sincos_q30(64'(s), 1'b1);
      v  = udiv64((sn << 16) + (cs >> 1), cs);
    end else begin
      sn = sincos_q30(64'(QTR - s), 1'b0);
      cs = sincos_q30(64'(QTR - s), 1'b1);
      if (sn == 0) v = 64'(TAN_SAT);
      else v = udiv64((cs << 16) + (sn >> 1), sn);
    end
    if (v > 64'(TAN_SAT)) v = 64'(TAN_SAT);
    return TAN_W'(v);
  endfunction

  // entry i holds |tan| of i+1 steps
  function automatic tan_rom_t tan_rom_init();
    tan_rom_t rom;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      rom[i] = tan_entry(i + 1);
    end
    return rom;
  endfunction

  localparam tan_rom_t TAN_ROM = tan_rom_init();

endpackage

### rtl/grw_in_if.sv
// Ray request channel.
interface grw_in_if;
  import grw_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] player_x;
  logic [COORD_W-1:0] player_y;
  logic [ANGLE_W-1:0] ray_angle;

  modport source (output valid, output player_x, output player_y, output ray_angle,
                  input ready);
  modport sink   (input valid, input player_x, input player_y, input ray_angle,
                  output ready);
endinterface

### rtl/grw_out_if.sv
// Wall hit result channel.
interface grw_out_if;
  import grw_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] horiz_end_x;
  logic signed [OUT_W-1:0] horiz_end_y;
  logic                    horiz_hit;
  logic signed [OUT_W-1:0] vert_end_x;
  logic signed [OUT_W-1:0] vert_end_y;
  logic                    vert_hit;

  modport source (output valid, output horiz_end_x, output horiz_end_y, output horiz_hit,
                  output vert_end_x, output vert_end_y, output vert_hit, input ready);
  modport sink   (input valid, input horiz_end_x, input horiz_end_y, input horiz_hit,
                  input vert_end_x, input vert_end_y, input vert_hit, output ready);
endinterface

### rtl/grw_setup.sv
// Three-stage cast setup: tangent lookup, first-line offset multiply, start point and step.
module grw_setup (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [grw_pkg::COORD_W-1:0]  player_x,
  input  logic [grw_pkg::COORD_W-1:0]  player_y,
  input  logic [grw_pkg::ANGLE_W-1:0]  ray_angle,
  output logic                         out_valid,
  output grw_pkg::cast_t               horiz,
  output grw_pkg::cast_t               vert
);
  import grw_pkg::*;

  localparam int TN_W      = COORD_W - POS_SHIFT;
  localparam int STEPSUM_W = TAN_W + POS_SHIFT + 1;
  localparam int STEP_W    = STEPSUM_W - 16;
  localparam int OFF_W     = PROD_W + 1 - 16;

  localparam logic [ANGLE_W-1:0] A_QTR  = ANGLE_W'(QTR);
  localparam logic [ANGLE_W-1:0] A_HALF = ANGLE_W'(HALF);
  localparam logic [ANGLE_W-1:0] A_3QTR = ANGLE_W'(3 * QTR);

  localparam logic signed [POS_W-1:0] TILE_S = POS_W'(TILE_Q8);

  typedef struct packed {
    logic                    neg;
    logic [TAN_W-1:0]        mag;
    logic [DIST_W-1:0]       d;
    logic signed [POS_W-1:0] pos0;   // coordinate on the first grid line
    logic                    fwd;    // stepping toward +axis
    logic                    triv;   // ray runs along this cast's lines
  } leg1_t;

  typedef struct packed {
    logic                    neg;
    logic [PROD_W-1:0]       prod;
    logic [STEP_W-1:0]       step;
    logic signed [POS_W-1:0] pos0;
    logic                    fwd;
    logic                    triv;
  } leg2_t;

  // {sign, |tan|} for an angle code
  function automatic logic [TAN_W:0] tan_lookup(input logic [ANGLE_W-1:0] b);
    logic [ANGLE_W-2:0] r;
    logic               neg;
    logic [IDX_W-1:0]   idx;
    r   = b[ANGLE_W-2:0];
    neg = r > (ANGLE_W-1)'(QTR);
    // second-quadrant codes mirror onto the first: HALF-1-r is ~r here
    idx = neg ? ~r[IDX_W-1:0] : r[IDX_W-1:0] - 1'b1;
    tan_lookup = (r == '0) ? '0 : {neg, TAN_ROM[idx]};
  endfunction

  function automatic leg1_t leg_start(input logic [ANGLE_W-1:0] b, input logic fwd,
                                      input logic triv, input logic [COORD_W-1:0] p);
    leg1_t                   l;
    logic signed [POS_W-1:0] base;
    logic [POS_SHIFT-1:0]    frac;
    base = $signed(POS_W'({p[COORD_W-1 -: TN_W], {POS_SHIFT{1'b0}}}));
    frac = p[POS_SHIFT-1:0];
    {l.neg, l.mag} = tan_lookup(b);
    l.fwd  = fwd;
    l.triv = triv;
    if (fwd) begin
      l.pos0 = base + TILE_S;
      l.d    = DIST_W'(TILE_Q8) - DIST_W'(frac);
    end else begin
      l.pos0 = base - POS_W'(1);
      l.d    = DIST_W'(frac) + DIST_W'(1);
    end
    return l;
  endfunction

  function automatic leg2_t leg_mul(input leg1_t l);
    leg2_t                r;
    logic [STEPSUM_W-1:0] ssum;
    ssum   = (STEPSUM_W'(l.mag) << POS_SHIFT) + STEPSUM_W'(32768);
    r.neg  = l.neg;
    r.prod = PROD_W'(l.d) * PROD_W'(l.mag);
    r.step = ssum[STEPSUM_W-1:16];
    r.pos0 = l.pos0;
    r.fwd  = l.fwd;
    r.triv = l.triv;
    return r;
  endfunction

  logic                    v1, v2;
  logic [COORD_W-1:0]      px1, py1, px2, py2;
  leg1_t                   h1, vt1;
  leg2_t                   h2, vt2;

  logic [PROD_W:0]         h_osum, v_osum;
  logic [OFF_W-1:0]        h_off, v_off;
  logic                    h_e, v_e;
  logic signed [POS_W-1:0] h_soff, v_soff, h_sstep, v_sstep, px_s, py_s;
  grw_pkg::cast_t          h_next, v_next;

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1 <= player_x;
      py1 <= player_y;
      h1  <= leg_start(A_QTR - ray_angle, ray_angle < A_HALF,
                       (ray_angle == '0) || (ray_angle == A_HALF), player_y);
      vt1 <= leg_start(ray_angle, (ray_angle < A_QTR) || (ray_angle > A_3QTR),
                       (ray_angle == A_QTR) || (ray_angle == A_3QTR), player_x);
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px2 <= px1;
      py2 <= py1;
      h2  <= leg_mul(h1);
      vt2 <= leg_mul(vt1);
    end
  end

  // stage 3
  always_comb begin
    px_s    = $signed(POS_W'(px2));
    py_s    = $signed(POS_W'(py2));
    h_osum  = (PROD_W + 1)'(h2.prod) + (PROD_W + 1)'(32768);
    v_osum  = (PROD_W + 1)'(vt2.prod) + (PROD_W + 1)'(32768);
    h_off   = h_osum[PROD_W:16];
    v_off   = v_osum[PROD_W:16];
    // effective sign: tangent sign, flipped when stepping toward -axis
    h_e     = h2.neg ^ ~h2.fwd;
    v_e     = vt2.neg ^ ~vt2.fwd;
    h_soff  = h_e ? -$signed(POS_W'(h_off)) : $signed(POS_W'(h_off));
    v_soff  = v_e ? -$signed(POS_W'(v_off)) : $signed(POS_W'(v_off));
    h_sstep = h_e ? -$signed(POS_W'(h2.step)) : $signed(POS_W'(h2.step));
    v_sstep = v_e ? -$signed(POS_W'(vt2.step)) : $signed(POS_W'(vt2.step));

    if (h2.triv) begin
      h_next = '{rx: px_s, ry: py_s, sx: '0, sy: '0, done: 1'b1, hit: 1'b0};
    end else begin
      h_next = '{rx: px_s + h_soff, ry: h2.pos0, sx: h_sstep,
                 sy: (h2.fwd ? TILE_S : -TILE_S), done: 1'b0, hit: 1'b0};
    end

    if (vt2.triv) begin
      v_next = '{rx: px_s, ry: py_s, sx: '0, sy: '0, done: 1'b1, hit: 1'b0};
    end else begin
      v_next = '{rx: vt2.pos0, ry: py_s + v_soff, sx: (vt2.fwd ? TILE_S : -TILE_S),
                 sy: v_sstep, done: 1'b0, hit: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      horiz <= h_next;
      vert  <= v_next;
    end
  end

endmodule

### rtl/grw_march.sv
// One tile step of a cast: wall test at the current point, else advance.
module grw_march (
  input  logic                       clk,
  input  logic                       en,
  input  logic [grw_pkg::MAP_W-1:0]  wall_map,
  input  grw_pkg::cast_t             cin,
  output grw_pkg::cast_t             cout
);
  import grw_pkg::*;

  localparam int TILE_NUM_W = POS_W - POS_SHIFT;
  localparam int CELL_W     = TILE_NUM_W + 4;
  localparam int MAP_IDX_W  = $clog2(CELLS);

  logic signed [TILE_NUM_W-1:0] row, col;
  logic signed [CELL_W-1:0]     flat_idx;
  logic                         wall;
  cast_t                        nxt;

  always_comb begin
    // arithmetic shift gives floor for negative positions
    row      = cin.ry[POS_W-1:POS_SHIFT];
    col      = cin.rx[POS_W-1:POS_SHIFT];
    // columns outside the map alias into neighboring rows; only the flat index is range checked
    flat_idx = CELL_W'(row * MAP_SIDE + col);
    wall     = (flat_idx >= 0) && (flat_idx < CELLS) && wall_map[flat_idx[MAP_IDX_W-1:0]];
    nxt      = cin;
    if (!cin.done) begin
      if (wall) begin
        nxt.done = 1'b1;
        nxt.hit  = 1'b1;
      end else begin
        nxt.rx = cin.rx + cin.sx;
        nxt.ry = cin.ry + cin.sy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout <= nxt;
    end
  end

endmodule

### rtl/grid_ray_wall_hit.sv
// Top level of the grid ray caster: config port, setup, step chains, output register.
// Takes one ray per cycle while the output is not held and returns one result per ray, in
// order, through three setup stages (tangent ROM lookup, the offset multiply, start point),
// one stage per tile step for the two casts side by side (eight), and the output register
// with saturation. The whole pipeline advances together, so a held result stalls every
// stage and ready drops in the same cycle. wall_map sits at byte address 0 and is written
// with an APB access cycle; it should change only while no ray is in flight.
module grid_ray_wall_hit (
  input  logic                        clk,
  input  logic                        rst,
  grw_in_if.sink                      rays,
  grw_out_if.source                   hits,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [grw_pkg::CFG_AW-1:0]  paddr,
  input  logic [grw_pkg::CFG_DW-1:0]  pwdata,
  output logic [grw_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import grw_pkg::*;

  logic                 en;
  logic [MAP_W-1:0]     wall_map;
  logic                 sel_wall;
  logic                 setup_valid;
  cast_t                chain_h [MAX_STEPS+1];
  cast_t                chain_v [MAX_STEPS+1];
  logic [MAX_STEPS-1:0] march_valid;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [POS_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > $signed(POS_W'(OUT_MAX))) r = OUT_W'(OUT_MAX);
    else if (v < $signed(POS_W'(OUT_MIN))) r = OUT_W'(OUT_MIN);
    else r = v[OUT_W-1:0];
    return r;
  endfunction

  // config port
  assign pready   = 1'b1;
  assign sel_wall = paddr[CFG_AW-1:3] == REG_WALL_MAP;
  assign prdata   = sel_wall ? CFG_DW'(wall_map) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_map <= '0;
    end else if (psel && penable && pwrite && pready && sel_wall) begin
      wall_map <= MAP_W'(pwdata);
    end
  end

  assign en         = !hits.valid || hits.ready;
  assign rays.ready = en;

  grw_setup u_setup (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rays.valid),
    .player_x  (rays.player_x),
    .player_y  (rays.player_y),
    .ray_angle (rays.ray_angle),
    .out_valid (setup_valid),
    .horiz     (chain_h[0]),
    .vert      (chain_v[0])
  );

  for (genvar i = 0; i < MAX_STEPS; i++) begin : g_step
    grw_march u_march_h (
      .clk      (clk),
      .en       (en),
      .wall_map (wall_map),
      .cin      (chain_h[i]),
      .cout     (chain_h[i+1])
    );
    grw_march u_march_v (
      .clk      (clk),
      .en       (en),
      .wall_map (wall_map),
      .cin      (chain_v[i]),
      .cout     (chain_v[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      march_valid <= '0;
    end else if (en) begin
      march_valid[0] <= setup_valid;
      for (int i = 1; i < MAX_STEPS; i++) begin
        march_valid[i] <= march_valid[i-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hits.valid <= 1'b0;
    end else if (en) begin
      hits.valid <= march_valid[MAX_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hits.horiz_end_x <= sat_out(chain_h[MAX_STEPS].rx);
      hits.horiz_end_y <= sat_out(chain_h[MAX_STEPS].ry);
      hits.horiz_hit   <= chain_h[MAX_STEPS].hit;
      hits.vert_end_x  <= sat_out(chain_v[MAX_STEPS].rx);
      hits.vert_end_y  <= sat_out(chain_v[MAX_STEPS].ry);
      hits.vert_hit    <= chain_v[MAX_STEPS].hit;
    end
  end

endmodule

### rtl/grw_checker.sv
// Port-level checks for the grid ray caster, bound to the top level.
`include "grid_ray_wall_hit_macros.svh"

module grw_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [4*grw_pkg::OUT_W+1:0] out_beat
);
  import grw_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

  logic [CNT_W-1:0] pending;   // beats taken in, not yet delivered

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + CNT_W'(in_valid && in_ready) - CNT_W'(out_valid && out_ready);
    end
  end

  `GRW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat))
  `GRW_ASSERT(a_no_phantom, out_valid, pending != '0)
  `GRW_ASSERT(a_depth, 1'b1, pending <= CNT_W'(PIPE_DEPTH))
  `GRW_ASSERT(a_stall_cause, !in_ready, out_valid && !out_ready)

endmodule

bind grid_ray_wall_hit grw_checker u_grw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (rays.valid),
  .in_ready  (rays.ready),
  .out_valid (hits.valid),
  .out_ready (hits.ready),
  .out_beat  ({hits.horiz_end_x, hits.horiz_end_y, hits.horiz_hit,
               hits.vert_end_x, hits.vert_end_y, hits.vert_hit})
);

### tb/sv/tb_grid_ray_wall_hit.sv
// Self-checking testbench for grid_ray_wall_hit: directed rows, random rays, wall map setups.
module tb_grid_ray_wall_hit;
  timeunit 1ns;
  timeprecision 1ps;

  import grw_pkg::*;

  // predictor geometry
  localparam int     TURN      = 1024;
  localparam int     QUARTER   = TURN / 4;
  localparam int     HALF_TURN = TURN / 2;
  localparam int     SIDE      = 8;
  localparam int     MARCH_MAX = 8;
  localparam int     TSHIFT    = 14;            // tile size in Q8
  localparam longint TILE      = 64'd1 << TSHIFT;
  localparam longint TAN_MAX   = 64'd2048 << 16;
  localparam longint OUT_HI    = 524287;
  localparam longint OUT_LO    = -524288;

  localparam logic [CFG_AW-1:0] WALL_ADDR = {REG_WALL_MAP, 3'b000};

  localparam logic [63:0] NO_WALLS  = 64'h0;
  localparam logic [63:0] ALL_WALLS = '1;
  localparam logic [63:0] WRAP_WALL = 64'h0000_0000_0000_0100;  // row 1, col 0
  localparam logic [63:0] BORDER    = 64'hFF81_8181_8181_81FF;
  localparam logic [63:0] CHECKER   = 64'hAA55_AA55_AA55_AA55;

  localparam int PHASES         = 7;
  localparam int RAYS_PER_PHASE = 250;
  localparam int QUIET_LIMIT    = 3000;
  localparam int MAX_REPORTS    = 100;

  typedef struct packed {
    logic signed [OUT_W-1:0] ex;
    logic signed [OUT_W-1:0] ey;
    logic                    hit;
  } leg_t;

  typedef struct packed {
    leg_t horiz;
    leg_t vert;
  } wall_hit_t;

  typedef struct packed {
    logic              typed;
    wall_hit_t         want;
  } hit_note_t;

  typedef struct packed {
    logic [63:0]        walls;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [ANGLE_W-1:0] ang;
    hit_note_t          note;
  } ray_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  grw_in_if  rays_if ();
  grw_out_if hits_if ();

  grid_ray_wall_hit dut (
    .clk     (clk),
    .rst     (rst),
    .rays    (rays_if),
    .hits    (hits_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0] wall_bits = NO_WALLS;
  wall_hit_t   hits_due [$];
  hit_note_t   typed_hits [$];
  ray_row_t    dir_rows [$];
  int          src_idle = 6;
  int          snk_idle = 67;
  int          errors = 0;
  int          n_rays = 0;
  int          n_results = 0;
  int          n_maps = 0;
  int          quiet_cycles = 0;

  // ---------------- predictor ----------------

  function automatic void sin_cos_q30(input int t, output longint sn, output longint cn);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned ts;
    longint unsigned tc;
    x  = (64'(t) * TWO_PI_Q30 + 64'(TURN / 2)) / 64'(TURN);
    x2 = (x * x) >> 30;
    ts = x;
    tc = ONE_Q30;
    sn = longint'(x);
    cn = longint'(ONE_Q30);
    for (int k = 1; k <= 6; k++) begin
      ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        sn = sn - longint'(ts);
        cn = cn - longint'(tc);
      end else begin
        sn = sn + longint'(ts);
        cn = cn + longint'(tc);
      end
    end
  endfunction

  // signed Q16 tangent, magnitude capped at 2048.0
  function automatic longint tan_q16(input int a);
    int     r;
    int     s;
    bit     neg;
    longint sn;
    longint cn;
    longint v;
    r = (a % TURN) % HALF_TURN;
    if (r == 0) return 0;
    if (r == QUARTER) return TAN_MAX;
    neg = (r > QUARTER);
    s = neg ? HALF_TURN - r : r;
    if (2 * s <= QUARTER) begin
      sin_cos_q30(s, sn, cn);
      v = ((sn <<< 16) + cn / 2) / cn;
    end else begin
      sin_cos_q30(QUARTER - s, sn, cn);
      v = (sn <= 0) ? TAN_MAX : ((cn <<< 16) + sn / 2) / sn;
    end
    if (v > TAN_MAX) v = TAN_MAX;
    return neg ? -v : v;
  endfunction

  // Q8 distance times Q16 tangent, back to Q8, halves away from zero
  function automatic longint scale_q8(input longint d, input longint tv);
    longint m;
    longint p;
    m = (tv < 0) ? -tv : tv;
    p = (d * m + 32768) >>> 16;
    return (tv < 0) ? -p : p;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(input longint v);
    if (v > OUT_HI) v = OUT_HI;
    if (v < OUT_LO) v = OUT_LO;
    return OUT_W'(v);
  endfunction

  function automatic leg_t walk_cast(input longint rx, input longint ry, input longint sx,
                                     input longint sy, input logic [63:0] cells);
    leg_t   leg;
    longint flat_idx;
    leg.hit = 1'b0;
    for (int i = 0; i < MARCH_MAX; i++) begin
      // floor division via arithmetic shift; off-map columns wrap into the next row
      flat_idx = (ry >>> TSHIFT) * SIDE + (rx >>> TSHIFT);
      if (flat_idx >= 0 && flat_idx < SIDE * SIDE && cells[int'(flat_idx)]) begin
        leg.hit = 1'b1;
        break;
      end
      rx = rx + sx;
      ry = ry + sy;
    end
    leg.ex = clamp_out(rx);
    leg.ey = clamp_out(ry);
    return leg;
  endfunction

  function automatic wall_hit_t cast_ray(input longint px, input longint py, input int a,
                                         input logic [63:0] cells);
    wall_hit_t r;
    longint    slope;
    longint    step;
    longint    rx;
    longint    ry;
    // horizontal grid lines use the cotangent
    if (a == 0 || a == HALF_TURN) begin
      r.horiz.ex  = clamp_out(px);
      r.horiz.ey  = clamp_out(py);
      r.horiz.hit = 1'b0;
    end else begin
      slope = tan_q16((QUARTER + TURN - a) % TURN);
      step  = scale_q8(TILE, slope);
      if (a < HALF_TURN) begin
        ry = ((py >>> TSHIFT) <<< TSHIFT) + TILE;
        rx = px + scale_q8(ry - py, slope);
        r.horiz = walk_cast(rx, ry, step, TILE, cells);
      end else begin
        ry = ((py >>> TSHIFT) <<< TSHIFT) - 1;   // one LSB short of the line
        rx = px - scale_q8(py - ry, slope);
        r.horiz = walk_cast(rx, ry, -step, -TILE, cells);
      end
    end
    if (a == QUARTER || a == 3 * QUARTER) begin
      r.vert.ex  = clamp_out(px);
      r.vert.ey  = clamp_out(py);
      r.vert.hit = 1'b0;
    end else begin
      slope = tan_q16(a);
      step  = scale_q8(TILE, slope);
      if (a < QUARTER || a > 3 * QUARTER) begin
        rx = ((px >>> TSHIFT) <<< TSHIFT) + TILE;
        ry = py + scale_q8(rx - px, slope);
        r.vert = walk_cast(rx, ry, TILE, step, cells);
      end else begin
        rx = ((px >>> TSHIFT) <<< TSHIFT) - 1;
        ry = py - scale_q8(px - rx, slope);
        r.vert = walk_cast(rx, ry, -TILE, -step, cells);
      end
    end
    return r;
  endfunction

  // ---------------- checking ----------------

  task automatic check_field(input string tag, input logic signed [OUT_W-1:0] want,
                             input logic signed [OUT_W-1:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
    end
  endtask

  always @(posedge clk) begin
    wall_hit_t got;
    wall_hit_t want;
    hit_note_t note;
    if (!rst) begin
      if (hits_if.valid && hits_if.ready) begin
        n_results++;
        got.horiz.ex  = hits_if.horiz_end_x;
        got.horiz.ey  = hits_if.horiz_end_y;
        got.horiz.hit = hits_if.horiz_hit;
        got.vert.ex   = hits_if.vert_end_x;
        got.vert.ey   = hits_if.vert_end_y;
        got.vert.hit  = hits_if.vert_hit;
        if (hits_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result beat with nothing expected, got %h", $time, got);
        end else begin
          want = hits_due.pop_front();
          check_field("horiz_end_x", want.horiz.ex, got.horiz.ex);
          check_field("horiz_end_y", want.horiz.ey, got.horiz.ey);
          check_field("horiz_hit", want.horiz.hit, got.horiz.hit);
          check_field("vert_end_x", want.vert.ex, got.vert.ex);
          check_field("vert_end_y", want.vert.ey, got.vert.ey);
          check_field("vert_hit", want.vert.hit, got.vert.hit);
        end
      end
      if (rays_if.valid && rays_if.ready) begin
        n_rays++;
        note = typed_hits.pop_front();
        if (note.typed)
          hits_due.push_back(note.want);
        else
          hits_due.push_back(cast_ray(longint'(rays_if.player_x), longint'(rays_if.player_y),
                                      int'(rays_if.ray_angle), wall_bits));
      end
      if ((hits_if.valid && hits_if.ready) || (rays_if.valid && rays_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
                 QUIET_LIMIT, hits_due.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------

  always @(negedge clk) begin
    hits_if.ready <= ($urandom_range(99) >= snk_idle);
  end

  // called and returns at a falling edge; valid stays up into the next ray
  task automatic send_ray(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                          input logic [ANGLE_W-1:0] a, input hit_note_t note);
    while ($urandom_range(99) < src_idle) begin
      rays_if.valid <= 1'b0;
      @(negedge clk);
    end
    typed_hits.push_back(note);
    rays_if.valid     <= 1'b1;
    rays_if.player_x  <= px;
    rays_if.player_y  <= py;
    rays_if.ray_angle <= a;
    @(posedge clk);
    while (!rays_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drain the pipeline, write wall_map, read it back
  task automatic load_wall_map(input logic [63:0] value);
    rays_if.valid <= 1'b0;
    while (hits_due.size() != 0) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WALL_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    wall_bits = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== value) begin
      errors++;
      $display("%0t: wall_map readback mismatch, expected %h, got %h", $time, value, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    n_maps++;
  endtask

  function automatic ray_row_t ray_row(input logic [63:0] m, input int px, input int py,
                                       input int a, input bit typed = 1'b0,
                                       input int hx = 0, input int hy = 0, input bit hh = 0,
                                       input int vx = 0, input int vy = 0,
                                       input bit vh = 0);
    ray_row_t row;
    row.walls               = m;
    row.px                  = COORD_W'(px);
    row.py                  = COORD_W'(py);
    row.ang                 = ANGLE_W'(a);
    row.note.typed          = typed;
    row.note.want.horiz.ex  = OUT_W'(hx);
    row.note.want.horiz.ey  = OUT_W'(hy);
    row.note.want.horiz.hit = hh;
    row.note.want.vert.ex   = OUT_W'(vx);
    row.note.want.vert.ey   = OUT_W'(vy);
    row.note.want.vert.hit  = vh;
    return row;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    int t;
    t = $urandom_range(7);
    case ($urandom_range(7))
      0: return $urandom_range(1) ? '1 : '0;
      1: return COORD_W'(t * TILE + ($urandom_range(1) ? 0 : TILE - 1));
      2: return COORD_W'(t * TILE + ($urandom_range(1) ? 1 : TILE - 2));
      default: return COORD_W'($urandom_range(131071));
    endcase
  endfunction

  // mostly any direction, some on or next to the four axes
  function automatic logic [ANGLE_W-1:0] pick_angle();
    int base;
    if ($urandom_range(7) == 0) begin
      base = QUARTER * $urandom_range(3);
      return ANGLE_W'(base + TURN + $urandom_range(2) - 1);
    end
    return ANGLE_W'($urandom_range(TURN - 1));
  endfunction

  initial begin
    logic [63:0] next_map;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    rays_if.valid    = 1'b0;
    rays_if.player_x = '0;
    rays_if.player_y = '0;
    rays_if.ray_angle = '0;
    hits_if.ready    = 1'b0;

    dir_rows = '{
      // reset map is empty: steps run out, axis-aligned casts return the player
      ray_row(NO_WALLS, 0, 0, 0, 1, 0, 0, 0, 147456, 0, 0),
      ray_row(NO_WALLS, 0, 0, QUARTER, 1, 0, 147456, 0, 0, 0, 0),
      ray_row(NO_WALLS, 131071, 131071, HALF_TURN, 1, 131071, 131071, 0, -16385, 131071, 0),
      ray_row(NO_WALLS, 131071, 131071, 3 * QUARTER, 1, 131071, -16385, 0, 131071, 131071, 0),
      // near the axes: steep slopes drive endpoints into saturation; the last two are diagonals
      ray_row(NO_WALLS, 65536, 65536, 1),
      ray_row(NO_WALLS, 65536, 65536, TURN - 1),
      ray_row(NO_WALLS, 40000, 90000, QUARTER - 1),
      ray_row(NO_WALLS, 40000, 90000, QUARTER + 1),
      ray_row(NO_WALLS, 100, 130000, HALF_TURN - 1),
      ray_row(NO_WALLS, 130000, 100, HALF_TURN + 1),
      ray_row(NO_WALLS, 70000, 70000, 3 * QUARTER - 1),
      ray_row(NO_WALLS, 70000, 70000, 3 * QUARTER + 1),
      ray_row(NO_WALLS, 16384, 16384, 128),
      ray_row(NO_WALLS, 16383, 16383, 640),
      // full map: first in-range cell hits; cell 0 counts
      ray_row(ALL_WALLS, 0, 0, 0, 1, 0, 0, 0, 16384, 0, 1),
      ray_row(ALL_WALLS, 131071, 131071, 0, 1, 131071, 131071, 0, 262144, 131071, 0),
      ray_row(ALL_WALLS, 0, 0, QUARTER, 1, 0, 16384, 1, 0, 0, 0),
      ray_row(ALL_WALLS, 2560, 2560, HALF_TURN, 1, 2560, 2560, 0, -131073, 2560, 0),
      ray_row(ALL_WALLS, 2560, 18944, 3 * QUARTER, 1, 2560, 16383, 1, 2560, 18944, 0),
      ray_row(ALL_WALLS, 131071, 0, 3),
      ray_row(ALL_WALLS, 77777, 33333, 300),
      // column 8 of row 0 wraps onto row 1, column 0
      ray_row(WRAP_WALL, 98404, 100, 0, 1, 98404, 100, 0, 131072, 100, 1),
      ray_row(WRAP_WALL, 500, 60000, 900),
      ray_row(CHECKER, 50000, 81000, 170),
      ray_row(CHECKER, 120000, 9000, 600)
    };

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].walls !== wall_bits) load_wall_map(dir_rows[i].walls);
      send_ray(dir_rows[i].px, dir_rows[i].py, dir_rows[i].ang, dir_rows[i].note);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      src_idle = (ph < 2) ? 6 : (ph < 4) ? 67 : 0;
      snk_idle = (ph < 2) ? 67 : (ph < 4) ? 6 : 0;
      case (ph)
        0: next_map = {$urandom, $urandom} & {$urandom, $urandom};
        1: next_map = ALL_WALLS;
        2: next_map = {$urandom, $urandom};
        3: next_map = BORDER;
        4: next_map = NO_WALLS;
        5: next_map = {$urandom, $urandom} | {$urandom, $urandom};
        default: next_map = 64'd1 << $urandom_range(63);
      endcase
      load_wall_map(next_map);
      repeat (RAYS_PER_PHASE) send_ray(pick_coord(), pick_coord(), pick_angle(), '0);
    end

    rays_if.valid <= 1'b0;
    while (hits_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Cast %0d rays (%0d directed) under %0d wall map loads; %0d results compared.",
             n_rays, dir_rows.size(), n_maps, n_results);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/grw_pkg.sv
rtl/grw_in_if.sv
rtl/grw_out_if.sv
rtl/grw_setup.sv
rtl/grw_march.sv
rtl/grid_ray_wall_hit.sv
rtl/grw_checker.sv
tb/sv/tb_grid_ray_wall_hit.sv
